// ===== design/sgmd_pkg.sv =====
// ----------------------------------------------------------------------------
// sgmd_pkg
// Shared types, register indexes and constants of the Sobel gradient block.
// ----------------------------------------------------------------------------
package sgmd_pkg;

    localparam int PIX_W  = 8;
    localparam int GRAD_W = 11;
    localparam int CFG_W  = 12;
    localparam int DZ_W   = 10;
    localparam int IDX_W  = 2;
    localparam int SQ_W   = 17;
    localparam int ROOT_W = 9;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_DEAD_ZONE    = 2'd2;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [DZ_W-1:0]  DZ_RESET     = 10'd19;

    localparam logic [PIX_W-1:0] CLAMP_MAX = 8'd255;
    localparam logic [PIX_W-1:0] DIR_HALF  = 8'd127;
    localparam logic [31:0]      HALF_TURN = 32'h8000_0000;

    typedef struct packed {
        logic [CFG_W-1:0] frame_width;
        logic [CFG_W-1:0] frame_height;
        logic [DZ_W-1:0]  dead_zone;
    } cfg_t;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic                     frame_end;
        logic                     run_last;
    } grad_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_READ,
        F_EMIT
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQUARE,
        B_ITER,
        B_SCALE,
        B_OUT
    } back_state_t;

    // atan(2^-i) in turns, one turn = 2^32
    function automatic logic [31:0] atan_turns(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            5'd24:   v = 32'd41;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/sgmd_stream_if.sv =====
// ----------------------------------------------------------------------------
// sgmd_stream_if
// Pixel stream channel: valid/ready with item kind and grey pixel.
// ----------------------------------------------------------------------------
interface sgmd_stream_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] pixel;

    modport source (output valid, output kind, output pixel, input ready);
    modport sink   (input valid, input kind, input pixel, output ready);
endinterface

// ===== design/sgmd_result_if.sv =====
// ----------------------------------------------------------------------------
// sgmd_result_if
// Result channel: valid/ready with gradient, magnitude and direction fields.
// ----------------------------------------------------------------------------
interface sgmd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] grad_x_abs;
    logic [7:0] grad_y_abs;
    logic [7:0] magnitude;
    logic [7:0] direction_code;
    logic       frame_end;
    logic       run_last;

    modport source (output valid, output grad_x_abs, output grad_y_abs, output magnitude,
                    output direction_code, output frame_end, output run_last, input ready);
    modport sink   (input valid, input grad_x_abs, input grad_y_abs, input magnitude,
                    input direction_code, input frame_end, input run_last, output ready);
endinterface

// ===== design/sgmd_ram.sv =====
// ----------------------------------------------------------------------------
// sgmd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sgmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/sgmd_fifo.sv =====
// ----------------------------------------------------------------------------
// sgmd_fifo
// Short queue of gradient jobs between the front and back parts.
// ----------------------------------------------------------------------------
module sgmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sgmd_pkg::grad_t push_data,
    output logic           full,
    input  logic           pop,
    output sgmd_pkg::grad_t pop_data,
    output logic           empty
);

    localparam int AW = $clog2(sgmd_pkg::QUEUE_DEPTH);

    sgmd_pkg::grad_t mem_reg [sgmd_pkg::QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW:0]     count_reg;

    assign full     = (count_reg == (AW+1)'(sgmd_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (AW+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (AW+1)'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue pop while empty");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + (AW+1)'(1))
        else $error("queue count did not advance");

endmodule

// ===== design/sgmd_front.sv =====
// ----------------------------------------------------------------------------
// sgmd_front
// Accepts pixels and drain ticks, keeps line stores, window and counters,
// and queues the Sobel sums for each result.
// ----------------------------------------------------------------------------
module sgmd_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic             clk,
    input  logic             rst_n,
    input  sgmd_pkg::cfg_t   cfg,
    sgmd_stream_if.sink      stream,
    output logic             push,
    output sgmd_pkg::grad_t  push_data,
    input  logic             full
);

    localparam int CW = $clog2(MAX_WIDTH);

    sgmd_pkg::front_state_t state_reg, state_next;
    logic                    kind_reg;
    logic [7:0]              pixel_reg;
    logic [CW-1:0]           addr_reg;
    logic [CW-1:0]           col_reg, col_next;
    logic [CW-1:0]           drain_reg, drain_next;
    logic [11:0]             row_reg, row_next;
    logic                    flush_reg, flush_next;
    logic [7:0]              win_reg [9];
    logic [7:0]              win_next [9];
    logic                    e_first_reg, e_first_next;
    logic                    e_left1_reg, e_left1_next;
    logic                    e_second_reg, e_second_next;
    logic                    e_fe_reg, e_fe_next;
    logic                    load;

    logic          accept;
    logic [CW-1:0] rd_addr;
    logic [7:0]    mid_rd, top_rd;
    logic [7:0]    top_v, bot_v;
    logic [11:0]   r_eff;
    logic [CW-1:0] wm1;
    logic [11:0]   hm1;
    logic          wr_en;
    logic [1:0]    l_sel, c_sel;
    logic [9:0]    sum_l, sum_r, sum_t, sum_b;

    assign stream.ready = (state_reg == sgmd_pkg::F_IDLE);
    assign accept       = stream.valid && stream.ready;
    assign rd_addr      = stream.kind ? drain_reg : col_reg;
    assign wr_en        = (state_reg == sgmd_pkg::F_READ) && !kind_reg;

    always_comb
    begin
        if (cfg.frame_width < 12'd2)
        begin
            wm1 = CW'(1);
        end
        else if (int'(cfg.frame_width) > MAX_WIDTH)
        begin
            wm1 = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            wm1 = CW'(cfg.frame_width - 12'd1);
        end
        hm1 = (cfg.frame_height < 12'd2) ? 12'd1 : cfg.frame_height - 12'd1;
    end

    sgmd_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_mid_line (
        .clk     (clk),
        .we      (wr_en),
        .wr_addr (addr_reg),
        .wr_data (pixel_reg),
        .re      (accept),
        .rd_addr (rd_addr),
        .rd_data (mid_rd)
    );

    sgmd_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_top_line (
        .clk     (clk),
        .we      (wr_en),
        .wr_addr (addr_reg),
        .wr_data (mid_rd),
        .re      (accept),
        .rd_addr (rd_addr),
        .rd_data (top_rd)
    );

    always_comb
    begin
        r_eff = flush_reg ? 12'd0 : row_reg;
        if (kind_reg)
        begin
            top_v = top_rd;
            bot_v = mid_rd;
        end
        else
        begin
            top_v = (r_eff == 12'd1) ? mid_rd : top_rd;
            bot_v = pixel_reg;
        end
    end

    always_comb
    begin
        if (e_first_reg)
        begin
            l_sel = e_left1_reg ? 2'd1 : 2'd0;
            c_sel = 2'd1;
        end
        else
        begin
            l_sel = 2'd1;
            c_sel = 2'd2;
        end
        sum_l = {2'b0, win_reg[l_sel]} + {1'b0, win_reg[3 + l_sel], 1'b0}
              + {2'b0, win_reg[6 + l_sel]};
        sum_r = {2'b0, win_reg[2]} + {1'b0, win_reg[5], 1'b0} + {2'b0, win_reg[8]};
        sum_t = {2'b0, win_reg[l_sel]} + {1'b0, win_reg[c_sel], 1'b0} + {2'b0, win_reg[2]};
        sum_b = {2'b0, win_reg[6 + l_sel]} + {1'b0, win_reg[6 + c_sel], 1'b0}
              + {2'b0, win_reg[8]};
        push_data.gx        = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
        push_data.gy        = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
        push_data.frame_end = e_first_reg ? 1'b0 : e_fe_reg;
        push_data.run_last  = e_first_reg ? !e_second_reg : 1'b1;
    end

    always_comb
    begin
        state_next    = state_reg;
        col_next      = col_reg;
        drain_next    = drain_reg;
        row_next      = row_reg;
        flush_next    = flush_reg;
        e_first_next  = e_first_reg;
        e_left1_next  = e_left1_reg;
        e_second_next = e_second_reg;
        e_fe_next     = e_fe_reg;
        win_next      = win_reg;
        load          = 1'b0;
        push          = 1'b0;
        case (state_reg)
            sgmd_pkg::F_IDLE:
            begin
                if (accept && (!stream.kind || flush_reg))
                begin
                    load       = 1'b1;
                    state_next = sgmd_pkg::F_READ;
                end
            end
            sgmd_pkg::F_READ:
            begin
                win_next[0] = win_reg[1];
                win_next[1] = win_reg[2];
                win_next[2] = top_v;
                win_next[3] = win_reg[4];
                win_next[4] = win_reg[5];
                win_next[5] = mid_rd;
                win_next[6] = win_reg[7];
                win_next[7] = win_reg[8];
                win_next[8] = bot_v;
                e_first_next  = (kind_reg || r_eff != 12'd0) && (addr_reg != '0);
                e_second_next = (kind_reg || r_eff != 12'd0) && (addr_reg >= wm1);
                e_left1_next  = (addr_reg == CW'(1));
                e_fe_next     = kind_reg;
                if (kind_reg)
                begin
                    if (addr_reg >= wm1)
                    begin
                        flush_next = 1'b0;
                        drain_next = '0;
                        row_next   = '0;
                        col_next   = '0;
                    end
                    else
                    begin
                        drain_next = addr_reg + CW'(1);
                    end
                end
                else
                begin
                    if (flush_reg)
                    begin
                        flush_next = 1'b0;
                        drain_next = '0;
                        row_next   = '0;
                    end
                    if (addr_reg >= wm1)
                    begin
                        col_next = '0;
                        if (r_eff >= hm1)
                        begin
                            flush_next = 1'b1;
                            drain_next = '0;
                        end
                        else
                        begin
                            row_next = r_eff + 12'd1;
                        end
                    end
                    else
                    begin
                        col_next = addr_reg + CW'(1);
                    end
                end
                if (e_first_next || e_second_next)
                begin
                    state_next = sgmd_pkg::F_EMIT;
                end
                else
                begin
                    state_next = sgmd_pkg::F_IDLE;
                end
            end
            sgmd_pkg::F_EMIT:
            begin
                if (!full)
                begin
                    push = 1'b1;
                    if (e_first_reg)
                    begin
                        e_first_next = 1'b0;
                        if (!e_second_reg)
                        begin
                            state_next = sgmd_pkg::F_IDLE;
                        end
                    end
                    else
                    begin
                        e_second_next = 1'b0;
                        state_next    = sgmd_pkg::F_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sgmd_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= stream.kind;
            pixel_reg <= stream.pixel;
            addr_reg  <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sgmd_pkg::F_IDLE;
            col_reg      <= '0;
            drain_reg    <= '0;
            row_reg      <= '0;
            flush_reg    <= 1'b0;
            e_first_reg  <= 1'b0;
            e_left1_reg  <= 1'b0;
            e_second_reg <= 1'b0;
            e_fe_reg     <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            drain_reg    <= drain_next;
            row_reg      <= row_next;
            flush_reg    <= flush_next;
            e_first_reg  <= e_first_next;
            e_left1_reg  <= e_left1_next;
            e_second_reg <= e_second_next;
            e_fe_reg     <= e_fe_next;
            win_reg      <= win_next;
        end
    end

endmodule

// ===== design/sgmd_back.sv =====
// ----------------------------------------------------------------------------
// sgmd_back
// Turns queued Sobel sums into clamped gradients, magnitude and direction
// using an iterative CORDIC and a bitwise square root.
// ----------------------------------------------------------------------------
module sgmd_back #(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [9:0]      dead_zone,
    input  logic            empty,
    input  sgmd_pkg::grad_t pop_data,
    output logic            pop,
    sgmd_result_if.source   result
);

    localparam int XW = 13 + ANGLE_FRAC_BITS;
    localparam int SW = $clog2(ANGLE_FRAC_BITS);

    sgmd_pkg::back_state_t state_reg, state_next;
    logic [7:0]           ax_reg, ay_reg;
    logic [16:0]          sq_reg;
    logic [8:0]           root_reg;
    logic signed [XW-1:0] x_reg, y_reg;
    logic [31:0]          z_reg;
    logic [SW-1:0]        step_reg;
    logic                 dead_reg, gyz_reg, gxneg_reg, fe_reg, last_reg;
    logic [7:0]           out_gx_reg, out_gy_reg, out_mag_reg, out_dir_reg;
    logic                 out_fe_reg, out_last_reg;

    logic [10:0]          abs_x, abs_y;
    logic signed [11:0]   dzs, gx12, gy12;
    logic signed [XW-1:0] x_init, y_init, x_sh, y_sh;
    logic [3:0]           bit_idx;
    logic [8:0]           trial;
    logic [17:0]          trial_sq;
    logic [ANGLE_FRAC_BITS-1:0]   theta;
    logic [ANGLE_FRAC_BITS+7:0]   theta_prod;
    logic [7:0]           dir_code;

    assign result.valid          = (state_reg == sgmd_pkg::B_OUT);
    assign result.grad_x_abs     = out_gx_reg;
    assign result.grad_y_abs     = out_gy_reg;
    assign result.magnitude      = out_mag_reg;
    assign result.direction_code = out_dir_reg;
    assign result.frame_end      = out_fe_reg;
    assign result.run_last       = out_last_reg;

    always_comb
    begin
        abs_x  = pop_data.gx[10] ? 11'(-pop_data.gx) : pop_data.gx;
        abs_y  = pop_data.gy[10] ? 11'(-pop_data.gy) : pop_data.gy;
        dzs    = $signed({2'b0, dead_zone});
        gx12   = 12'(pop_data.gx);
        gy12   = 12'(pop_data.gy);
        x_init = pop_data.gx[10] ? XW'(-gx12) : XW'(gx12);
        y_init = pop_data.gx[10] ? XW'(-gy12) : XW'(gy12);
        x_sh   = x_reg >>> step_reg;
        y_sh   = y_reg >>> step_reg;
        bit_idx  = 4'd8 - 4'(step_reg);
        trial    = root_reg | (9'd1 << bit_idx);
        trial_sq = trial * trial;
        theta      = z_reg[31 -: ANGLE_FRAC_BITS];
        theta_prod = theta * 8'd255;
        dir_code   = theta_prod[ANGLE_FRAC_BITS +: 8];
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        case (state_reg)
            sgmd_pkg::B_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    state_next = sgmd_pkg::B_SQUARE;
                end
            end
            sgmd_pkg::B_SQUARE:
            begin
                state_next = sgmd_pkg::B_ITER;
            end
            sgmd_pkg::B_ITER:
            begin
                if (step_reg == SW'(ANGLE_FRAC_BITS - 1))
                begin
                    state_next = sgmd_pkg::B_SCALE;
                end
            end
            sgmd_pkg::B_SCALE:
            begin
                state_next = sgmd_pkg::B_OUT;
            end
            sgmd_pkg::B_OUT:
            begin
                if (result.ready)
                begin
                    state_next = sgmd_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = sgmd_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            sgmd_pkg::B_IDLE:
            begin
                ax_reg    <= (abs_x > 11'd255) ? sgmd_pkg::CLAMP_MAX : abs_x[7:0];
                ay_reg    <= (abs_y > 11'd255) ? sgmd_pkg::CLAMP_MAX : abs_y[7:0];
                dead_reg  <= (gx12 < dzs) && (gx12 > -dzs) && (gy12 < dzs) && (gy12 > -dzs);
                gyz_reg   <= (pop_data.gy == '0);
                gxneg_reg <= pop_data.gx[10];
                fe_reg    <= pop_data.frame_end;
                last_reg  <= pop_data.run_last;
                x_reg     <= x_init <<< ANGLE_FRAC_BITS;
                y_reg     <= y_init <<< ANGLE_FRAC_BITS;
                z_reg     <= pop_data.gx[10] ? sgmd_pkg::HALF_TURN : '0;
            end
            sgmd_pkg::B_SQUARE:
            begin
                sq_reg   <= ({9'b0, ax_reg} * {9'b0, ax_reg})
                          + ({9'b0, ay_reg} * {9'b0, ay_reg});
                root_reg <= '0;
                step_reg <= '0;
            end
            sgmd_pkg::B_ITER:
            begin
                if (y_reg > 0)
                begin
                    x_reg <= x_reg + y_sh;
                    y_reg <= y_reg - x_sh;
                    z_reg <= z_reg + sgmd_pkg::atan_turns(5'(step_reg));
                end
                else
                begin
                    x_reg <= x_reg - y_sh;
                    y_reg <= y_reg + x_sh;
                    z_reg <= z_reg - sgmd_pkg::atan_turns(5'(step_reg));
                end
                if ((step_reg < SW'(9)) && (trial_sq <= {1'b0, sq_reg}))
                begin
                    root_reg <= trial;
                end
                step_reg <= step_reg + SW'(1);
            end
            sgmd_pkg::B_SCALE:
            begin
                out_gx_reg   <= ax_reg;
                out_gy_reg   <= ay_reg;
                out_mag_reg  <= (root_reg > 9'd255) ? sgmd_pkg::CLAMP_MAX : root_reg[7:0];
                out_fe_reg   <= fe_reg;
                out_last_reg <= last_reg;
                if (dead_reg)
                begin
                    out_dir_reg <= '0;
                end
                else if (gyz_reg)
                begin
                    out_dir_reg <= gxneg_reg ? sgmd_pkg::DIR_HALF : '0;
                end
                else
                begin
                    out_dir_reg <= dir_code;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sgmd_pkg::B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/sobel_gradient_mag_dir.sv =====
// ----------------------------------------------------------------------------
// sobel_gradient_mag_dir
// Sobel 3x3 edge magnitude and direction over a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   stream carries pixels (kind 0) in raster order and drain ticks (kind 1);
//   result carries one item per output pixel, run_last marking the final
//   result of an input item and frame_end the frame's last pixel.
//   Configuration: cfg_we, cfg_index, cfg_data write frame_width,
//   frame_height and dead_zone; write them only while the block is idle.
//   Results lag by one row and one pixel; after a frame's last pixel send
//   frame_width drain ticks to flush the final row.
//   Per item the front reads the line stores, then makes one queue write
//   per result it produces, waiting while the queue is full; it takes no new
//   item until then. The back works each result through the iterative
//   CORDIC and the output handshake before it pops the next one; it bounds
//   the sustained rate.
//   Reset clears counters, window and queue; line stores are unset until
//   written, which a full first row always does. When result stalls, the
//   back holds its output and the four-entry queue fills, then stream
//   ready drops.
// ----------------------------------------------------------------------------
module sobel_gradient_mag_dir #(
    parameter int MAX_WIDTH       = 2048,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    sgmd_stream_if.sink   stream,
    sgmd_result_if.source result
);

    sgmd_pkg::cfg_t  cfg_reg;
    sgmd_pkg::grad_t push_data, pop_data;
    logic            push, pop, full, empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= sgmd_pkg::WIDTH_RESET;
            cfg_reg.frame_height <= sgmd_pkg::HEIGHT_RESET;
            cfg_reg.dead_zone    <= sgmd_pkg::DZ_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sgmd_pkg::REG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_data;
                sgmd_pkg::REG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data;
                sgmd_pkg::REG_DEAD_ZONE:    cfg_reg.dead_zone    <= cfg_data[9:0];
                default:
                begin
                end
            endcase
        end
    end

    sgmd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .stream    (stream),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    sgmd_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    sgmd_back #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .dead_zone (cfg_reg.dead_zone),
        .empty     (empty),
        .pop_data  (pop_data),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ===== test/sobel_gradient_mag_dir_tb.sv =====
// ----------------------------------------------------------------------------
// sobel_gradient_mag_dir_tb
// Self-checking bench for the Sobel gradient magnitude and direction block.
// Small frames in raster order plus drain ticks go in over the stream channel
// with random gaps. A bench-side gradient model predicts every result, and
// each result is compared field by field. Geometry and dead zone are changed
// between frames, including saturated and extreme settings.
// ----------------------------------------------------------------------------
module sobel_gradient_mag_dir_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_MAX   = 2048;
    localparam int ANGLE_BITS = 16;
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;
    localparam int SETTLE = 60;

    typedef struct {
        logic [7:0] gxa;
        logic [7:0] gya;
        logic [7:0] mag;
        logic [7:0] dir;
        logic       fe;
        logic       rl;
    } grad_result_t;

    typedef struct {
        logic       kind;
        logic [7:0] pixel;
        logic       known;
    } stim_row_t;

    typedef enum int { PAT_RANDOM, PAT_RAMP, PAT_EDGE, PAT_EXTREME } pattern_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [11:0] cfg_data;

    sgmd_stream_if stream ();
    sgmd_result_if result ();

    sobel_gradient_mag_dir DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stream    (stream.sink),
        .result    (result.source)
    );

    // predictor state
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [9:0]  dz_reg;
    logic [7:0]  line_mem [0:2*LINE_MAX-1];
    logic [7:0]  win [0:8];
    int unsigned col_cnt, row_cnt, drain_cnt;
    bit          flushing;

    grad_result_t expected_q[$];
    int mismatches;
    int results_seen;
    int items_sent;
    int frames_done;
    bit quiet;

    const logic [31:0] atan_lut [0:15] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
        32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
        32'd166886, 32'd83443, 32'd41722, 32'd20861
    };

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int unsigned used_width();
        int unsigned w;
        w = width_reg;
        if (w < 2) w = 2;
        if (w > LINE_MAX) w = LINE_MAX;
        return w;
    endfunction

    function automatic int unsigned used_height();
        return (height_reg < 2) ? 2 : height_reg;
    endfunction

    function automatic logic [7:0] angle_code(int gx, int gy);
        longint x, y, nx;
        logic [31:0] z;
        logic [31:0] theta;
        int dz;
        dz = dz_reg;
        z = '0;
        if (gx < dz && gx > -dz && gy < dz && gy > -dz) return 8'd0;
        if (gy == 0) return (gx >= 0) ? 8'd0 : sgmd_pkg::DIR_HALF;
        x = gx;
        y = gy;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = sgmd_pkg::HALF_TURN;
        end
        x = x <<< ANGLE_BITS;
        y = y <<< ANGLE_BITS;
        for (int i = 0; i < ANGLE_BITS; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_lut[i];
            end
            else
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_lut[i];
            end
            x = nx;
        end
        theta = z >> (32 - ANGLE_BITS);
        return 8'((longint'(theta) * 255) >> ANGLE_BITS);
    endfunction

    function automatic grad_result_t window_gradient(int l, int c, int r, bit fe);
        grad_result_t g;
        int gx, gy, ax, ay, s, root;
        gx = (win[r] + 2 * win[3+r] + win[6+r]) - (win[l] + 2 * win[3+l] + win[6+l]);
        gy = (win[6+l] + 2 * win[6+c] + win[6+r]) - (win[l] + 2 * win[c] + win[r]);
        ax = (gx < 0) ? -gx : gx;
        ay = (gy < 0) ? -gy : gy;
        if (ax > 255) ax = 255;
        if (ay > 255) ay = 255;
        s = ax * ax + ay * ay;
        root = 0;
        while ((root + 1) * (root + 1) <= s) root++;
        if (root > 255) root = 255;
        g.gxa = 8'(ax);
        g.gya = 8'(ay);
        g.mag = 8'(root);
        g.dir = angle_code(gx, gy);
        g.fe  = fe;
        g.rl  = 1'b0;
        return g;
    endfunction

    task automatic shift_window(logic [7:0] t, logic [7:0] m, logic [7:0] b);
        logic [7:0] v [0:2];
        v[0] = t;
        v[1] = m;
        v[2] = b;
        for (int k = 0; k < 3; k++)
        begin
            win[k*3]   = win[k*3+1];
            win[k*3+1] = win[k*3+2];
            win[k*3+2] = v[k];
        end
    endtask

    task automatic queue_row_results(int unsigned c, int unsigned w, bit last_row,
                                     bit known);
        grad_result_t g [$];
        grad_result_t z;
        if (c >= 1) g.push_back(window_gradient((c == 1) ? 1 : 0, 1, 2, 1'b0));
        if (c >= w - 1) g.push_back(window_gradient(1, 2, 2, last_row));
        if (g.size() > 0) g[g.size()-1].rl = 1'b1;
        foreach (g[k])
        begin
            if (known)
            begin
                z = g[k];
                z.gxa = '0;
                z.gya = '0;
                z.mag = '0;
                z.dir = '0;
                g[k] = z;
            end
            expected_q.push_back(g[k]);
        end
    endtask

    task automatic restart_frame();
        flushing = 0;
        drain_cnt = 0;
        row_cnt = 0;
        col_cnt = 0;
    endtask

    task automatic predict_gradients(logic kind, logic [7:0] pix, bit known);
        int unsigned w, h, c, r;
        logic [7:0] t, m;
        w = used_width();
        h = used_height();
        if (kind == KIND_DRAIN)
        begin
            if (!flushing) return;
            c = (drain_cnt >= LINE_MAX) ? LINE_MAX - 1 : drain_cnt;
            t = line_mem[LINE_MAX + c];
            m = line_mem[c];
            shift_window(t, m, m);
            queue_row_results(c, w, 1'b1, known);
            if (c >= w - 1) restart_frame();
            else drain_cnt = c + 1;
            return;
        end
        if (flushing) restart_frame();
        r = row_cnt;
        c = (col_cnt >= LINE_MAX) ? LINE_MAX - 1 : col_cnt;
        m = line_mem[c];
        t = (r == 1) ? m : line_mem[LINE_MAX + c];
        line_mem[LINE_MAX + c] = m;
        line_mem[c] = pix;
        shift_window(t, m, pix);
        if (r >= 1) queue_row_results(c, w, 1'b0, known);
        if (c >= w - 1)
        begin
            col_cnt = 0;
            if (r >= h - 1)
            begin
                flushing = 1;
                drain_cnt = 0;
            end
            else
                row_cnt = (r + 1) & 12'hFFF;
        end
        else
            col_cnt = (c + 1) & 11'h7FF;
    endtask

    task automatic send_item(logic kind, logic [7:0] pix, bit known);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            stream.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stream.valid <= 1'b1;
        stream.kind  <= kind;
        stream.pixel <= pix;
        do @(posedge clk); while (!stream.ready);
        predict_gradients(kind, pix, known);
        items_sent++;
    endtask

    task automatic wait_idle();
        stream.valid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [11:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            sgmd_pkg::REG_FRAME_WIDTH:  width_reg  = data;
            sgmd_pkg::REG_FRAME_HEIGHT: height_reg = data;
            sgmd_pkg::REG_DEAD_ZONE:    dz_reg     = data[9:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(logic [11:0] w, logic [11:0] h, logic [11:0] dz);
        wait_idle();
        write_reg(sgmd_pkg::REG_FRAME_WIDTH, w);
        write_reg(sgmd_pkg::REG_FRAME_HEIGHT, h);
        write_reg(sgmd_pkg::REG_DEAD_ZONE, dz);
    endtask

    function automatic logic [7:0] frame_pixel(pattern_t p, int unsigned r, int unsigned c,
                                              int unsigned seed);
        case (p)
            PAT_RAMP:    return 8'(seed + r * (seed[3:0] + 1) + c * seed[7:4]);
            PAT_EDGE:    return (((r + seed[1:0]) ^ (c + seed[3:2])) & 2) ? 8'hFF : 8'h00;
            PAT_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            default:     return 8'($urandom);
        endcase
    endfunction

    // full frame, optional stray drains mid-frame, then a complete or cut flush
    task automatic run_frame(pattern_t p, bit cut_flush);
        int unsigned w, h, seed, n;
        w = used_width();
        h = used_height();
        seed = $urandom;
        for (int unsigned r = 0; r < h; r++)
            for (int unsigned c = 0; c < w; c++)
            begin
                if ($urandom_range(0, 40) == 0) send_item(KIND_DRAIN, 8'($urandom), 0);
                send_item(KIND_PIXEL, frame_pixel(p, r, c, seed), 0);
            end
        n = cut_flush ? $urandom_range(0, w - 1) : w;
        for (int unsigned k = 0; k < n; k++) send_item(KIND_DRAIN, 8'($urandom), 0);
        frames_done++;
    endtask

    stim_row_t directed [$];

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        stream.valid = 1'b0;
        stream.kind  = KIND_PIXEL;
        stream.pixel = '0;
        width_reg    = sgmd_pkg::WIDTH_RESET;
        height_reg   = sgmd_pkg::HEIGHT_RESET;
        dz_reg       = sgmd_pkg::DZ_RESET;
        foreach (win[k]) win[k] = '0;
        foreach (line_mem[k]) line_mem[k] = '0;
        restart_frame();
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        frames_done = 0;
        quiet = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle drain, flat frames, full-swing edges, cut flush
        directed = '{
            '{KIND_DRAIN, 8'hFF, 1},
            '{KIND_PIXEL, 8'h00, 1}, '{KIND_PIXEL, 8'h00, 1},
            '{KIND_PIXEL, 8'h00, 1}, '{KIND_PIXEL, 8'h00, 1},
            '{KIND_DRAIN, 8'h00, 1}, '{KIND_DRAIN, 8'h00, 1},
            '{KIND_DRAIN, 8'h00, 1},
            '{KIND_PIXEL, 8'hFF, 1}, '{KIND_PIXEL, 8'hFF, 1},
            '{KIND_PIXEL, 8'hFF, 1}, '{KIND_PIXEL, 8'hFF, 1},
            '{KIND_DRAIN, 8'h00, 1}, '{KIND_DRAIN, 8'h00, 1},
            '{KIND_PIXEL, 8'h00, 0}, '{KIND_PIXEL, 8'hFF, 0},
            '{KIND_PIXEL, 8'hFF, 0}, '{KIND_PIXEL, 8'h00, 0},
            '{KIND_DRAIN, 8'h00, 0},
            '{KIND_PIXEL, 8'h00, 0}, '{KIND_PIXEL, 8'h00, 0},
            '{KIND_PIXEL, 8'hFF, 0}, '{KIND_PIXEL, 8'hFF, 0},
            '{KIND_DRAIN, 8'h00, 0}, '{KIND_DRAIN, 8'h00, 0}
        };
        set_geometry(12'd2, 12'd2, 12'd0);
        foreach (directed[k]) send_item(directed[k].kind, directed[k].pixel, directed[k].known);

        set_geometry(12'd3, 12'd3, 12'd1023);
        run_frame(PAT_EXTREME, 0);

        // saturated and extreme geometry
        set_geometry(12'd0, 12'd0, 12'd1020);
        run_frame(PAT_EDGE, 0);
        set_geometry(12'd1, 12'd1, 12'd0);
        run_frame(PAT_RANDOM, 0);
        set_geometry(12'd24, 12'd2, 12'd19);
        run_frame(PAT_RAMP, 0);
        set_geometry(12'd2, 12'd30, 12'd5);
        run_frame(PAT_RANDOM, 0);

        // random phases over small frames
        for (int ph = 0; ph < 10; ph++)
        begin
            set_geometry(12'($urandom_range(2, 9)), 12'($urandom_range(2, 7)),
                         12'($urandom_range(0, 3) == 0 ? $urandom_range(0, 4095)
                                                       : $urandom_range(0, 40)));
            if (ph == 8) quiet = 1;
            for (int f = 0; f < 2; f++)
                run_frame(pattern_t'($urandom_range(0, 3)), $urandom_range(0, 4) == 0);
        end

        wait_idle();
        $display("Covered %0d items in %0d frames, %0d results checked.",
                 items_sent, frames_done, results_seen);
        $display("Geometry from saturated 2x2 up to 24 wide and 30 tall, dead zone 0 to 1023.");
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // receiver with random stall bursts
    int stall_left;
    initial
    begin
        result.ready = 1'b0;
        stall_left = 0;
    end
    always @(posedge clk)
    begin
        if (quiet)
            result.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            result.ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 4);
            result.ready <= 1'b0;
        end
        else
            result.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        grad_result_t e;
        if (rst_n && result.valid && result.ready)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: gx %0d gy %0d mag %0d dir %0d",
                             result.grad_x_abs, result.grad_y_abs, result.magnitude,
                             result.direction_code);
            end
            else
            begin
                e = expected_q.pop_front();
                if (result.grad_x_abs !== e.gxa || result.grad_y_abs !== e.gya ||
                    result.magnitude !== e.mag || result.direction_code !== e.dir ||
                    result.frame_end !== e.fe || result.run_last !== e.rl)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch at result %0d: exp gx %0d gy %0d mag %0d dir %0d",
                                  " fe %0b last %0b, got gx %0d gy %0d mag %0d dir %0d",
                                  " fe %0b last %0b"},
                                 results_seen, e.gxa, e.gya, e.mag, e.dir, e.fe, e.rl,
                                 result.grad_x_abs, result.grad_y_abs, result.magnitude,
                                 result.direction_code, result.frame_end, result.run_last);
                end
            end
        end
    end

    initial
    begin
        #60_000_000;
        $display("timeout with %0d results outstanding", expected_q.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
